### hdl/rgb_to_cct_and_lux_unit_defines.svh
// Assertion macros shared by the checker of the color temperature unit.
`ifndef RGB_TO_CCT_AND_LUX_UNIT_DEFINES_SVH
`define RGB_TO_CCT_AND_LUX_UNIT_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define RCL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Asserts that a condition never holds.
`define RCL_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### hdl/rcl_pkg.sv
// Shared constants for the color temperature and illuminance unit.
package rcl_pkg;

   // Color matrix, Q2.14, rows X, Y, Z and columns red, green, blue.
   localparam logic signed [15:0] MTX_XR = -16'sd2340;
   localparam logic signed [15:0] MTX_XG = 16'sd25383;
   localparam logic signed [15:0] MTX_XB = -16'sd15670;
   localparam logic signed [15:0] MTX_YR = -16'sd5319;
   localparam logic signed [15:0] MTX_YG = 16'sd25860;
   localparam logic signed [15:0] MTX_YB = -16'sd11992;
   localparam logic signed [15:0] MTX_ZR = -16'sd11174;
   localparam logic signed [15:0] MTX_ZG = 16'sd12628;
   localparam logic signed [15:0] MTX_ZB = 16'sd9229;

   // Width of X, Y, Z, their sum and all divider operands.
   localparam int OPND_W = 34;
   // Quotient bits produced by the divider (the sign is separate).
   localparam int QUO_BITS = 31;
   // Divider stages: input stage, one stage per bit, output stage.
   localparam int DIV_LAT = QUO_BITS + 2;
   // Reciprocal of ten scaled by 2^34, rounded up.
   localparam int RECIP_SHIFT = 34;
   localparam logic [30:0] RECIP_10 = 31'd1717986919;
   // Stage counts of the front end and the polynomial, and the total depth.
   localparam int FRONT_LAT = 3;
   localparam int POLY_LAT = 6;
   localparam int LATENCY = FRONT_LAT + DIV_LAT + 1 + DIV_LAT + 1 + POLY_LAT;

endpackage

### hdl/rcl_xyz.sv
// Color matrix stages: products, XYZ sums, chromaticity sum and lux.
module rcl_xyz
   import rcl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [15:0]               red,
   input  logic [15:0]               green,
   input  logic [15:0]               blue,
   output logic                      out_valid,
   output logic signed [OPND_W-1:0]  x_val,
   output logic signed [OPND_W-1:0]  y_val,
   output logic signed [OPND_W-1:0]  s_val,
   output logic [15:0]               lux
);

   logic               vld_ff [0:2];
   logic signed [32:0] prod_ff [0:8];
   logic signed [32:0] prod_in [0:8];
   logic signed [OPND_W-1:0] x_ff, y_ff, z_ff;
   logic signed [OPND_W-1:0] xo_ff, yo_ff, so_ff;
   logic [15:0]        lux_ff, lux_in;
   logic signed [16:0] r_s, g_s, b_s;

   assign r_s = signed'({1'b0, red});
   assign g_s = signed'({1'b0, green});
   assign b_s = signed'({1'b0, blue});

   // Nine constant products, each 17 by 16 bits.
   always_comb begin
      prod_in[0] = 33'(r_s) * 33'(MTX_XR);
      prod_in[1] = 33'(g_s) * 33'(MTX_XG);
      prod_in[2] = 33'(b_s) * 33'(MTX_XB);
      prod_in[3] = 33'(r_s) * 33'(MTX_YR);
      prod_in[4] = 33'(g_s) * 33'(MTX_YG);
      prod_in[5] = 33'(b_s) * 33'(MTX_YB);
      prod_in[6] = 33'(r_s) * 33'(MTX_ZR);
      prod_in[7] = 33'(g_s) * 33'(MTX_ZG);
      prod_in[8] = 33'(b_s) * 33'(MTX_ZB);
   end

   // Illuminance is Y / 2^14 toward zero, saturated to 16 bits.
   always_comb begin
      if (y_ff < 0) begin
         lux_in = 16'd0;
      end else if (|y_ff[OPND_W-1:30]) begin
         lux_in = 16'hffff;
      end else begin
         lux_in = y_ff[29:14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
         vld_ff[2] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff <= OPND_W'(prod_ff[0]) + OPND_W'(prod_ff[1]) + OPND_W'(prod_ff[2]);
      y_ff <= OPND_W'(prod_ff[3]) + OPND_W'(prod_ff[4]) + OPND_W'(prod_ff[5]);
      z_ff <= OPND_W'(prod_ff[6]) + OPND_W'(prod_ff[7]) + OPND_W'(prod_ff[8]);
      xo_ff <= x_ff;
      yo_ff <= y_ff;
      so_ff <= x_ff + y_ff + z_ff;
      lux_ff <= lux_in;
   end

   assign out_valid = vld_ff[2];
   assign x_val = xo_ff;
   assign y_val = yo_ff;
   assign s_val = so_ff;
   assign lux = lux_ff;

endmodule

### hdl/rcl_qdiv.sv
// Pipelined signed fixed-point divider, one quotient bit per stage.
module rcl_qdiv
   import rcl_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W = 1
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [OPND_W-1:0] num,
   input  logic signed [OPND_W-1:0] den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [31:0]       quo,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int SHW = OPND_W + QUO_BITS;
   localparam int IPW = QUO_BITS - FRAC_BITS;

   logic [OPND_W-1:0]           an, ad;
   logic [OPND_W+FRAC_BITS-1:0] ash;
   logic                        sat_in;

   logic                vld_ff  [0:QUO_BITS+1];
   logic [OPND_W:0]     rem_ff  [0:QUO_BITS];
   logic [QUO_BITS-1:0] low_ff  [0:QUO_BITS];
   logic [QUO_BITS-1:0] q_ff    [0:QUO_BITS];
   logic [OPND_W-1:0]   ad_ff   [0:QUO_BITS];
   logic                neg_ff  [0:QUO_BITS];
   logic                sat_ff  [0:QUO_BITS];
   logic [SIDE_W-1:0]   side_ff [0:QUO_BITS];
   logic signed [31:0]  quo_ff;
   logic [SIDE_W-1:0]   oside_ff;
   logic [31:0]         mag;

   // Magnitudes and the overflow test against den * 2^(31-F).
   assign an = num[OPND_W-1] ? OPND_W'(-num) : OPND_W'(num);
   assign ad = den[OPND_W-1] ? OPND_W'(-den) : OPND_W'(den);
   assign ash = {an, FRAC_BITS'(0)};
   assign sat_in = SHW'(an) >= (SHW'(ad) << IPW);

   // Input stage: partial remainder from the integer bits.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= (OPND_W + 1)'(an >> IPW);
      low_ff[0]  <= ash[QUO_BITS-1:0];
      q_ff[0]    <= '0;
      ad_ff[0]   <= ad;
      neg_ff[0]  <= num[OPND_W-1] ^ den[OPND_W-1];
      sat_ff[0]  <= sat_in;
      side_ff[0] <= in_side;
   end

   // One restoring step per stage.
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
      logic [OPND_W+1:0] trial;
      logic              take;
      assign trial = {rem_ff[k], low_ff[k][QUO_BITS-1]};
      assign take = trial >= {2'b00, ad_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take ? (OPND_W + 1)'(trial - {2'b00, ad_ff[k]})
                              : trial[OPND_W:0];
         low_ff[k+1]  <= {low_ff[k][QUO_BITS-2:0], 1'b0};
         q_ff[k+1]    <= {q_ff[k][QUO_BITS-2:0], take};
         ad_ff[k+1]   <= ad_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         sat_ff[k+1]  <= sat_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   // Output stage: saturation and sign.
   always_comb begin
      if (sat_ff[QUO_BITS]) begin
         mag = neg_ff[QUO_BITS] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         mag = {1'b0, q_ff[QUO_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= neg_ff[QUO_BITS] ? signed'(-mag) : signed'(mag);
      oside_ff <= side_ff[QUO_BITS];
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUO_BITS + 1; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= QUO_BITS + 1; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[QUO_BITS+1];
   assign quo = quo_ff;
   assign out_side = oside_ff;

endmodule

### hdl/rcl_poly.sv
// McCamy cubic pipeline: powers of n, weighted sum and final clamp.
module rcl_poly
   import rcl_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [FRAC_BITS+5:0] n_val,
   input  logic                        in_invalid,
   input  logic [15:0]                 in_lux,
   output logic                        out_valid,
   output logic [15:0]                 color_temp,
   output logic [15:0]                 lux,
   output logic                        cct_invalid
);

   localparam int NW  = FRAC_BITS + 6;
   localparam int N2W = FRAC_BITS + 10;
   localparam int N3W = FRAC_BITS + 14;
   localparam int CW  = N2W + NW;
   localparam int LW  = NW + 14;
   localparam int PW  = FRAC_BITS + 25;
   localparam int TW  = NW + 2 + 31;
   localparam longint C0 = ((longint'(552033) <<< FRAC_BITS) + 50) / 100;

   logic             vld_ff  [0:POLY_LAT-1];
   logic             inv_ff  [0:POLY_LAT-1];
   logic [15:0]      lux_ff  [0:POLY_LAT-1];

   // Stage one registers.
   logic signed [2*NW-1:0] sq_ff;
   logic [NW+1:0]          a3_ff;
   logic signed [NW+13:0]  lh1_ff;
   logic signed [NW-1:0]   n1_ff;
   logic                   neg1_ff;
   // Stage two registers.
   logic signed [N2W-1:0]  n2a_ff;
   logic [TW-1:0]          tq_ff;
   logic signed [NW+13:0]  lh2_ff;
   logic signed [NW-1:0]   n2n_ff;
   logic                   neg2_ff;
   // Stage three registers.
   logic signed [CW-1:0]   cube_ff;
   logic signed [LW-1:0]   lin3_ff;
   logic signed [N2W-1:0]  n2b_ff;
   logic                   neg3_ff;
   // Stage four registers.
   logic signed [N3W-1:0]  n3_ff;
   logic signed [LW-1:0]   lin4_ff;
   logic signed [N2W-1:0]  n2c_ff;
   // Stage five registers.
   logic signed [PW-1:0]   t3_ff, t2_ff;
   // Output register.
   logic [15:0]            cct_ff, cct_in;

   logic [NW-2:0]          q10;
   logic signed [LW-1:0]   q10_s;
   logic signed [CW-1:0]   cube_adj;
   logic signed [PW-1:0]   poly;
   logic [NW-1:0]          n_abs;

   assign n_abs = n_val[NW-1] ? NW'(-n_val) : NW'(n_val);

   // Stage one: square, |3n| and the integer part of 6823.3 n.
   always_ff @(posedge clock) begin
      sq_ff   <= n_val * n_val;
      a3_ff   <= (NW + 2)'(n_abs) * (NW + 2)'(3);
      lh1_ff  <= (NW + 14)'(n_val) * (NW + 14)'(6823);
      n1_ff   <= n_val;
      neg1_ff <= n_val[NW-1];
   end

   // Stage two: n^2 and the reciprocal product for 3n / 10.
   always_ff @(posedge clock) begin
      n2a_ff  <= sq_ff[FRAC_BITS+N2W-1:FRAC_BITS];
      tq_ff   <= TW'(a3_ff) * TW'(RECIP_10);
      lh2_ff  <= lh1_ff;
      n2n_ff  <= n1_ff;
      neg2_ff <= neg1_ff;
   end

   // Stage three: n^2 * n and the linear term.
   assign q10 = tq_ff[RECIP_SHIFT+NW-2:RECIP_SHIFT];
   assign q10_s = signed'(LW'(q10));

   always_ff @(posedge clock) begin
      cube_ff <= CW'(n2a_ff) * CW'(n2n_ff);
      lin3_ff <= LW'(lh2_ff) + (neg2_ff ? -q10_s : q10_s);
      n2b_ff  <= n2a_ff;
      neg3_ff <= neg2_ff;
   end

   // Stage four: n^3 divided by 2^F toward zero.
   assign cube_adj = cube_ff + (neg3_ff ? CW'((longint'(1) <<< FRAC_BITS) - 1) : CW'(0));

   always_ff @(posedge clock) begin
      n3_ff   <= cube_adj[FRAC_BITS+N3W-1:FRAC_BITS];
      lin4_ff <= lin3_ff;
      n2c_ff  <= n2b_ff;
   end

   // Stage five: weighted terms.
   always_ff @(posedge clock) begin
      t3_ff <= PW'(n3_ff) * PW'(449);
      t2_ff <= PW'(n2c_ff) * PW'(3525) + PW'(lin4_ff) + PW'(C0);
   end

   // Output stage: integer kelvin, clamped to 0..65535, zero for an invalid item.
   assign poly = t3_ff + t2_ff;

   always_comb begin
      if (inv_ff[POLY_LAT-2] || poly[PW-1]) begin
         cct_in = 16'd0;
      end else if (|poly[PW-2:FRAC_BITS+16]) begin
         cct_in = 16'hffff;
      end else begin
         cct_in = poly[FRAC_BITS+15:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      cct_ff <= cct_in;
   end

   // Valid and side data follow the arithmetic.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POLY_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < POLY_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      inv_ff[0] <= in_invalid;
      lux_ff[0] <= in_lux;
      for (int i = 1; i < POLY_LAT; i++) begin
         inv_ff[i] <= inv_ff[i-1];
         lux_ff[i] <= lux_ff[i-1];
      end
   end

   assign out_valid = vld_ff[POLY_LAT-1];
   assign color_temp = cct_ff;
   assign lux = lux_ff[POLY_LAT-1];
   assign cct_invalid = inv_ff[POLY_LAT-1];

endmodule

### hdl/rgb_to_cct_and_lux_unit.sv
// Throughput: one item per cycle; busy is never raised, the pipeline never stalls.
// The depth is set by two pipelined dividers in series, 33 stages each (x and y side by side, then n).
// Reset clears every valid bit at once; items in flight are dropped.
// Top level of the color temperature and illuminance unit.
module rgb_to_cct_and_lux_unit
   import rcl_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_red,
   input  logic [15:0] req_green,
   input  logic [15:0] req_blue,
   output logic        rsp_valid,
   output logic [15:0] rsp_color_temp,
   output logic [15:0] rsp_lux,
   output logic        rsp_cct_invalid
);

   localparam int NW = FRAC_BITS + 6;
   localparam longint XC_OFF = ((longint'(332) <<< FRAC_BITS) + 500) / 1000;
   localparam longint YC_OFF = ((longint'(1858) <<< FRAC_BITS) + 5000) / 10000;
   localparam longint N_LIM = longint'(16) <<< FRAC_BITS;

   logic                     acc;
   logic                     xyz_vld;
   logic signed [OPND_W-1:0] x_val, y_val, s_val;
   logic [15:0]              xyz_lux;
   logic                     da_vld, db_vld;
   logic signed [31:0]       xc, yc;
   logic [15:0]              da_lux;
   logic                     db_szero;

   logic                     d_vld_ff;
   logic signed [OPND_W-1:0] nnum_ff, dden_ff;
   logic                     dinv_ff;
   logic [15:0]              dlux_ff;
   logic signed [OPND_W-1:0] dden_in;

   logic                     dc_vld;
   logic signed [31:0]       nq;
   logic [16:0]              dc_side;

   logic                     c_vld_ff;
   logic signed [NW-1:0]     n_ff;
   logic                     cinv_ff;
   logic [15:0]              clux_ff;

   assign busy = 1'b0;
   assign acc = start & ~busy;

   // Matrix and chromaticity sum.
   rcl_xyz u_xyz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (xyz_vld),
      .x_val     (x_val),
      .y_val     (y_val),
      .s_val     (s_val),
      .lux       (xyz_lux)
   );

   // Chromaticity x carries the lux value along.
   rcl_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W(16)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xyz_vld),
      .num       (x_val),
      .den       (s_val),
      .in_side   (xyz_lux),
      .out_valid (da_vld),
      .quo       (xc),
      .out_side  (da_lux)
   );

   // Chromaticity y carries the zero-sum flag along.
   rcl_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xyz_vld),
      .num       (y_val),
      .den       (s_val),
      .in_side   (s_val == '0),
      .out_valid (db_vld),
      .quo       (yc),
      .out_side  (db_szero)
   );

   // Operands of the McCamy quotient and the invalid test.
   assign dden_in = OPND_W'(YC_OFF) - OPND_W'(yc);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= da_vld & db_vld;
      end
   end

   always_ff @(posedge clock) begin
      nnum_ff <= OPND_W'(xc) - OPND_W'(XC_OFF);
      dden_ff <= dden_in;
      dinv_ff <= db_szero | (dden_in == '0);
      dlux_ff <= da_lux;
   end

   rcl_qdiv #(.FRAC_BITS(FRAC_BITS), .SIDE_W(17)) u_div_n (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .num       (nnum_ff),
      .den       (dden_ff),
      .in_side   ({dinv_ff, dlux_ff}),
      .out_valid (dc_vld),
      .quo       (nq),
      .out_side  (dc_side)
   );

   // Clamp n to plus or minus sixteen.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= dc_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (nq > 32'(N_LIM)) begin
         n_ff <= NW'(N_LIM);
      end else if (nq < -32'(N_LIM)) begin
         n_ff <= NW'(-N_LIM);
      end else begin
         n_ff <= NW'(nq);
      end
      cinv_ff <= dc_side[16];
      clux_ff <= dc_side[15:0];
   end

   rcl_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c_vld_ff),
      .n_val       (n_ff),
      .in_invalid  (cinv_ff),
      .in_lux      (clux_ff),
      .out_valid   (rsp_valid),
      .color_temp  (rsp_color_temp),
      .lux         (rsp_lux),
      .cct_invalid (rsp_cct_invalid)
   );

endmodule

### hdl/rcl_checker.sv
// Port-level checker for the color temperature unit, bound to the top level.
`include "rgb_to_cct_and_lux_unit_defines.svh"

module rcl_checker
   import rcl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_color_temp,
   input logic        rsp_cct_invalid
);

   // An invalid result always reports zero kelvin.
   `RCL_ASSERT_IMPL(a_inv_zero, clock, reset, rsp_valid && rsp_cct_invalid, rsp_color_temp == 16'd0, "invalid result with nonzero temperature")

   // Every result strobe stems from an item accepted at the offset LATENCY before it.
   `RCL_ASSERT_IMPL(a_rsp_origin, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result without a matching item")

   // The pipeline never holds items off.
   `RCL_ASSERT_NEVER(a_no_busy, clock, reset, busy, "busy raised")

endmodule

bind rgb_to_cct_and_lux_unit rcl_checker u_rcl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_color_temp  (rsp_color_temp),
   .rsp_cct_invalid (rsp_cct_invalid)
);

### sim/rgb_to_cct_and_lux_checker.sv
// Checker for the color temperature unit: watches both channels, predicts and compares.
module rgb_to_cct_and_lux_checker
   import rcl_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_red,
   input  logic [15:0] req_green,
   input  logic [15:0] req_blue,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_color_temp,
   input  logic [15:0] rsp_lux,
   input  logic        rsp_cct_invalid,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] color_temp;
      logic [15:0] lux;
      logic        cct_invalid;
   } reading_type;

   localparam longint ONE_Q = longint'(1) << FRAC_BITS;
   localparam longint XC_OFF = ((longint'(332) << FRAC_BITS) + 500) / 1000;
   localparam longint YC_OFF = ((longint'(1858) << FRAC_BITS) + 5000) / 10000;
   localparam longint CCT_C0 = ((longint'(552033) << FRAC_BITS) + 50) / 100;
   localparam longint N_CLAMP = longint'(16) << FRAC_BITS;

   reading_type expected_readings[$];

   // Signed fixed-point quotient, truncated toward zero, saturated to 32 bits.
   function automatic longint fixed_quotient(longint num, longint den);
      logic neg;
      longint unsigned an, ad, ip, rem, mag;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? longint'(0) - num : num;
      ad = (den < 0) ? longint'(0) - den : den;
      ip = an / ad;
      rem = an % ad;
      if (ip >= (longint'(1) << (31 - FRAC_BITS))) begin
         mag = neg ? (longint'(1) << 31) : ((longint'(1) << 31) - 1);
      end else begin
         mag = ip;
         for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            mag = mag << 1;
            if (rem >= ad) begin
               rem = rem - ad;
               mag = mag | 1;
            end
         end
         if (!neg && mag > ((longint'(1) << 31) - 1))
            mag = (longint'(1) << 31) - 1;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clip16(longint v);
      if (v < 0)
         return 0;
      if (v > 65535)
         return 65535;
      return v;
   endfunction

   // McCamy temperature and illuminance of one raw reading.
   function automatic reading_type predict_reading(logic [15:0] r, logic [15:0] g,
                                                   logic [15:0] b);
      reading_type res;
      longint cx, cy, cz, total, xc, yc, d, n, n2, n3, poly;
      cx = longint'(MTX_XR) * r + longint'(MTX_XG) * g + longint'(MTX_XB) * b;
      cy = longint'(MTX_YR) * r + longint'(MTX_YG) * g + longint'(MTX_YB) * b;
      cz = longint'(MTX_ZR) * r + longint'(MTX_ZG) * g + longint'(MTX_ZB) * b;
      total = cx + cy + cz;
      res.color_temp = '0;
      res.cct_invalid = 1'b0;
      if (total == 0) begin
         res.cct_invalid = 1'b1;
      end else begin
         xc = fixed_quotient(cx, total);
         yc = fixed_quotient(cy, total);
         d = YC_OFF - yc;
         if (d == 0) begin
            res.cct_invalid = 1'b1;
         end else begin
            n = fixed_quotient(xc - XC_OFF, d);
            if (n > N_CLAMP)
               n = N_CLAMP;
            if (n < -N_CLAMP)
               n = -N_CLAMP;
            n2 = (n * n) / ONE_Q;
            n3 = (n2 * n) / ONE_Q;
            poly = 449 * n3 + 3525 * n2 + (68233 * n) / 10 + CCT_C0;
            res.color_temp = (poly < 0) ? 16'd0 : 16'(clip16(poly / ONE_Q));
         end
      end
      res.lux = 16'(clip16(cy / 16384));
      return res;
   endfunction

   assign pending_count = expected_readings.size();

   // Predict on each accepted item and compare each result with the oldest one.
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         expected_readings.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result with no item waiting: temp %0d lux %0d invalid %0b",
                        $time, rsp_color_temp, rsp_lux, rsp_cct_invalid);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_readings.pop_front();
               if (want.color_temp !== rsp_color_temp || want.lux !== rsp_lux ||
                   want.cct_invalid !== rsp_cct_invalid) begin
                  $display("%0t: mismatch: expected temp %0d lux %0d invalid %0b, got %0d %0d %0b",
                           $time, want.color_temp, want.lux, want.cct_invalid,
                           rsp_color_temp, rsp_lux, rsp_cct_invalid);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_readings.push_back(predict_reading(req_red, req_green, req_blue));
      end
   end

   initial fail_count = 0;

endmodule

### sim/rgb_to_cct_and_lux_unit_tb.sv
// Testbench top for the color temperature unit: clock, reset, stimulus and verdict.
module rgb_to_cct_and_lux_unit_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_red = '0;
   logic [15:0] req_green = '0;
   logic [15:0] req_blue = '0;
   logic        rsp_valid;
   logic [15:0] rsp_color_temp;
   logic [15:0] rsp_lux;
   logic        rsp_cct_invalid;
   int          fail_count;
   int          pending_count;
   bit          allow_gaps = 1'b1;

   always #5 clock = ~clock;

   rgb_to_cct_and_lux_unit dut (.*);

   rgb_to_cct_and_lux_checker checker_i (.*);

   // Offer one reading, with a random gap first, and hold it until accepted.
   task automatic send_reading(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      while (allow_gaps && $urandom_range(99) < 35) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_red = r;
      req_green = g;
      req_blue = b;
      do @(posedge clock); while (busy);
   endtask

   // Random reading: raw full range, small counts, green dominant, or green above red above blue.
   task automatic send_random;
      int kind;
      logic [15:0] r, g, b;
      kind = $urandom_range(3);
      r = 16'($urandom);
      g = 16'($urandom);
      b = 16'($urandom);
      case (kind)
         1: begin
            r = 16'($urandom_range(255));
            g = 16'($urandom_range(255));
            b = 16'($urandom_range(255));
         end
         2: begin
            g = 16'($urandom_range(40000, 65535));
            r = 16'($urandom_range(0, g));
            b = 16'($urandom_range(0, g));
         end
         3: begin
            r = 16'($urandom_range(100, 20000));
            g = r + 16'($urandom_range(0, 8000));
            b = r - 16'($urandom_range(0, r / 2));
         end
         default: ;
      endcase
      send_reading(r, g, b);
   endtask

   initial begin
      int lat;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero sum, extremes, single channels, gray and skewed readings.
      send_reading(16'd0, 16'd0, 16'd0);
      send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_reading(16'hFFFF, 16'd0, 16'd0);
      send_reading(16'd0, 16'hFFFF, 16'd0);
      send_reading(16'd0, 16'd0, 16'hFFFF);
      send_reading(16'hFFFF, 16'hFFFF, 16'd0);
      send_reading(16'd0, 16'hFFFF, 16'hFFFF);
      send_reading(16'hFFFF, 16'd0, 16'hFFFF);
      send_reading(16'd1, 16'd1, 16'd1);
      send_reading(16'd1, 16'd0, 16'd0);
      send_reading(16'd0, 16'd1, 16'd0);
      send_reading(16'd0, 16'd0, 16'd1);
      send_reading(16'd1000, 16'd1000, 16'd1000);
      send_reading(16'd4000, 16'd6000, 16'd2000);
      send_reading(16'd2000, 16'd6000, 16'd6000);
      send_reading(16'd6000, 16'd5000, 16'd1000);
      send_reading(16'd30000, 16'd32000, 16'd30000);
      send_reading(16'h8000, 16'h8000, 16'h8000);
      send_reading(16'h5555, 16'hAAAA, 16'h5555);
      send_reading(16'hAAAA, 16'h5555, 16'hAAAA);

      // Let the pipeline drain completely before the random part.
      @(negedge clock);
      start = 1'b0;
      wait (pending_count == 0);

      for (int i = 0; i < 1300; i++) begin
         allow_gaps = !(i >= 400 && i < 600);
         send_random();
         if (i == 900) begin
            @(negedge clock);
            start = 1'b0;
            wait (pending_count == 0);
         end
      end
      @(negedge clock);
      start = 1'b0;

      wait (pending_count == 0);
      lat = rcl_pkg::LATENCY;
      repeat (lat + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Give up if the run hangs.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

### rgb_to_cct_and_lux_unit.f
+incdir+hdl
hdl/rcl_pkg.sv
hdl/rcl_xyz.sv
hdl/rcl_qdiv.sv
hdl/rcl_poly.sv
hdl/rgb_to_cct_and_lux_unit.sv
hdl/rcl_checker.sv
sim/rgb_to_cct_and_lux_checker.sv
sim/rgb_to_cct_and_lux_unit_tb.sv
